[hdl/rmaa_pkg.sv]
`default_nettype none
package rmaa_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int SQRT_ITERS   = 16;
  localparam int SQRT_LAT     = SQRT_ITERS + 1;
  localparam int CORDIC_STEPS = 18;
  localparam int DIV_BITS     = 16;
  localparam int BACK_LAT     = DIV_BITS + 2;
  localparam int ANGLE_HALF   = 46080;
  localparam int DEG90_Q16    = 90 * 65536;

  typedef enum logic [1:0] {
    CASE_GENERAL = 2'd0,
    CASE_ZERO    = 2'd1,
    CASE_HALF    = 2'd2,
    CASE_OOB     = 2'd3
  } case_code_t;

  // per-request data carried alongside the arithmetic units
  typedef struct packed {
    case_code_t         code;
    logic signed [16:0] u;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
    logic [15:0]        root;
  } side_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hdl/rmaa_sqrt.sv]
`default_nettype none
module rmaa_sqrt import rmaa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] rad,
  output logic      [15:0] root
);

  logic [30:0] m_r   [SQRT_ITERS];
  logic [30:0] r_r   [SQRT_ITERS];
  logic [30:0] m_nxt [SQRT_ITERS];
  logic [30:0] r_nxt [SQRT_ITERS];
  logic [15:0] root_r;

  genvar k;
  generate
    for (k = 0; k < SQRT_ITERS; k++) begin : g_it
      localparam logic [30:0] BIT = 31'(1) << (2 * (SQRT_ITERS - 1 - k));
      logic [30:0] m_in;
      logic [30:0] r_in;
      logic [31:0] trial;
      if (k == 0) begin : g_first
        assign m_in = rad;
        assign r_in = '0;
      end else begin : g_rest
        assign m_in = m_r[k-1];
        assign r_in = r_r[k-1];
      end
      assign trial = {1'b0, r_in} + {1'b0, BIT};
      always_comb begin
        if ({1'b0, m_in} >= trial) begin
          m_nxt[k] = 31'({1'b0, m_in} - trial);
          r_nxt[k] = (r_in >> 1) + BIT;
        end else begin
          m_nxt[k] = m_in;
          r_nxt[k] = r_in >> 1;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[k] <= m_nxt[k];
          r_r[k] <= r_nxt[k];
        end
      end
    end
  endgenerate

  // round to nearest: remainder above root means next integer is closer
  always_ff @(posedge clk) begin
    if (en) begin
      if (m_r[SQRT_ITERS-1] > r_r[SQRT_ITERS-1]) begin
        root_r <= 16'(r_r[SQRT_ITERS-1] + 31'd1);
      end else begin
        root_r <= r_r[SQRT_ITERS-1][15:0];
      end
    end
  end

  assign root = root_r;

endmodule
`default_nettype wire

[hdl/rmaa_cordic.sv]
`default_nettype none
module rmaa_cordic import rmaa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [16:0] u,
  input  wire logic        [15:0] s,
  output logic             [15:0] angle
);

  logic signed [35:0] x_r   [CORDIC_STEPS];
  logic signed [35:0] y_r   [CORDIC_STEPS];
  logic signed [31:0] z_r   [CORDIC_STEPS];
  logic signed [35:0] x_nxt [CORDIC_STEPS];
  logic signed [35:0] y_nxt [CORDIC_STEPS];
  logic signed [31:0] z_nxt [CORDIC_STEPS];

  logic signed [35:0] x0;
  logic signed [35:0] y0;
  logic signed [35:0] xp;
  logic signed [35:0] yp;
  logic signed [31:0] zp;

  assign x0 = $signed({{3{u[16]}}, u, 16'b0});
  assign y0 = $signed({4'b0, s, 16'b0});

  // left half plane: rotate by 90 degrees first
  always_comb begin
    if (x0 < 0) begin
      xp = y0;
      yp = -x0;
      zp = 32'(DEG90_Q16);
    end else begin
      xp = x0;
      yp = y0;
      zp = '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      localparam logic [4:0] IDX = 5'(k);
      logic signed [35:0] xi;
      logic signed [35:0] yi;
      logic signed [31:0] zi;
      logic signed [31:0] at;
      if (k == 0) begin : g_first
        assign xi = xp;
        assign yi = yp;
        assign zi = zp;
      end else begin : g_rest
        assign xi = x_r[k-1];
        assign yi = y_r[k-1];
        assign zi = z_r[k-1];
      end
      assign at = $signed({10'b0, atan_deg(IDX)});
      always_comb begin
        if (yi > 0) begin
          x_nxt[k] = xi + (yi >>> k);
          y_nxt[k] = yi - (xi >>> k);
          z_nxt[k] = zi + at;
        end else begin
          x_nxt[k] = xi - (yi >>> k);
          y_nxt[k] = yi + (xi >>> k);
          z_nxt[k] = zi - at;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= x_nxt[k];
          y_r[k] <= y_nxt[k];
          z_r[k] <= z_nxt[k];
        end
      end
    end
  endgenerate

  logic signed [31:0] zc;
  logic        [31:0] ang;

  always_comb begin
    zc  = (z_r[CORDIC_STEPS-1] < 0) ? 32'sd0 : z_r[CORDIC_STEPS-1];
    ang = (32'(zc) + 32'd128) >> 8;
    if (ang > 32'(ANGLE_HALF)) begin
      angle = 16'(ANGLE_HALF);
    end else begin
      angle = ang[15:0];
    end
  end

endmodule
`default_nettype wire

[hdl/rmaa_div.sv]
`default_nettype none
module rmaa_div import rmaa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [30:0] num,
  input  wire logic        [16:0] den,
  output logic signed      [15:0] quo
);

  typedef struct packed {
    logic neg;
    logic pos;
    logic dz;
    logic ovf;
  } div_flg_t;

  // prep stage: magnitude plus half divisor for round-to-nearest
  logic [30:0] a1_r;
  logic [16:0] den1_r;
  div_flg_t    flg1_r;
  logic [30:0] mag;
  logic [30:0] a1;

  assign mag = (num < 0) ? 31'(-num) : 31'(num);
  assign a1  = mag + 31'(den >> 1);

  // quotient too large for the bits computed below
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r        <= a1;
      den1_r      <= den;
      flg1_r.neg  <= (num < 0);
      flg1_r.pos  <= (num > 0);
      flg1_r.dz   <= (den == '0);
      flg1_r.ovf  <= ({2'b0, a1} >= {den, 16'b0});
    end
  end

  logic [30:0]         rem_r [DIV_BITS+1];
  logic [DIV_BITS-1:0] q_r   [DIV_BITS+1];
  logic [16:0]         den_r [DIV_BITS+1];
  div_flg_t            flg_r [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= a1_r;
      q_r[0]   <= '0;
      den_r[0] <= den1_r;
      flg_r[0] <= flg1_r;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= DIV_BITS; k++) begin : g_bit
      localparam int J = DIV_BITS - k;
      logic [31:0]         dsh;
      logic [30:0]         rem_nxt;
      logic [DIV_BITS-1:0] q_nxt;
      assign dsh = 32'(den_r[k-1]) << J;
      always_comb begin
        q_nxt = q_r[k-1];
        if ({1'b0, rem_r[k-1]} >= dsh) begin
          rem_nxt  = 31'({1'b0, rem_r[k-1]} - dsh);
          q_nxt[J] = 1'b1;
        end else begin
          rem_nxt = rem_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          q_r[k]   <= q_nxt;
          den_r[k] <= den_r[k-1];
          flg_r[k] <= flg_r[k-1];
        end
      end
    end
  endgenerate

  logic [DIV_BITS-1:0] q;
  div_flg_t            f;

  assign q = q_r[DIV_BITS];
  assign f = flg_r[DIV_BITS];

  always_comb begin
    if (f.dz) begin
      if (f.pos) begin
        quo = 16'sd32767;
      end else if (f.neg) begin
        quo = -16'sd32768;
      end else begin
        quo = '0;
      end
    end else if (f.neg) begin
      if (f.ovf || q > 16'd32768) begin
        quo = -16'sd32768;
      end else begin
        quo = $signed(16'(-q));
      end
    end else begin
      if (f.ovf || q[15]) begin
        quo = 16'sd32767;
      end else begin
        quo = $signed(q);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/rotation_matrix_to_axis_angle.sv]
// Converts a 3x3 rotation matrix (signed Q2.14 entries) to an angle in degrees
// (unsigned Q8.8), a rotation axis (Q2.14, saturated) and a case code. One
// matrix is accepted per cycle while in_stall is low; a result passes 37 register
// stages (1 trace/case stage, 17 square-root stages, 18 CORDIC/divider stages, 1
// output register). The depth is set by the one-bit-per-stage square root and
// dividers and the 18 CORDIC iterations. A stalled output holds the whole pipe.
`default_nettype none
module rotation_matrix_to_axis_angle import rmaa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_m11,
  input  wire logic signed [15:0] in_m12,
  input  wire logic signed [15:0] in_m13,
  input  wire logic signed [15:0] in_m21,
  input  wire logic signed [15:0] in_m22,
  input  wire logic signed [15:0] in_m23,
  input  wire logic signed [15:0] in_m31,
  input  wire logic signed [15:0] in_m32,
  input  wire logic signed [15:0] in_m33,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [15:0] out_angle_deg,
  output logic signed      [15:0] out_axis_x,
  output logic signed      [15:0] out_axis_y,
  output logic signed      [15:0] out_axis_z,
  output logic             [1:0]  out_case_code
);

  localparam logic signed [17:0] ONE_S   = 18'sd16384;
  localparam logic signed [17:0] THREE_S = 18'sd49152;
  localparam logic signed [17:0] TWO_S   = 18'sd32768;

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---- stage A: trace, case select, root argument
  logic signed [17:0] t;
  logic signed [17:0] u18;
  logic signed [17:0] h;
  logic        [16:0] dmu;
  logic        [16:0] dpu;
  logic        [33:0] prod;
  side_t              a_side_nxt;
  logic        [30:0] a_rad_nxt;

  assign t   = $signed({{2{in_m11[15]}}, in_m11}) + $signed({{2{in_m22[15]}}, in_m22})
             + $signed({{2{in_m33[15]}}, in_m33});
  assign u18 = t - ONE_S;
  assign h   = $signed({{2{in_m11[15]}}, in_m11}) + ONE_S;
  assign dmu = 17'(TWO_S - u18);
  assign dpu = 17'(TWO_S + u18);
  assign prod = 34'(dmu) * 34'(dpu);

  always_comb begin
    a_side_nxt.u    = u18[16:0];
    a_side_nxt.root = '0;
    a_side_nxt.n0   = $signed({in_m32[15], in_m32}) - $signed({in_m23[15], in_m23});
    a_side_nxt.n1   = $signed({in_m13[15], in_m13}) - $signed({in_m31[15], in_m31});
    a_side_nxt.n2   = $signed({in_m21[15], in_m21}) - $signed({in_m12[15], in_m12});
    a_rad_nxt       = '0;
    if (t == THREE_S) begin
      a_side_nxt.code = CASE_ZERO;
      a_side_nxt.n0   = $signed({in_m21[15], in_m21});
      a_side_nxt.n1   = $signed({in_m22[15], in_m22});
      a_side_nxt.n2   = $signed({in_m23[15], in_m23});
    end else if (t == -ONE_S) begin
      a_side_nxt.code = CASE_HALF;
      a_side_nxt.n1   = $signed({in_m21[15], in_m21});
      a_side_nxt.n2   = $signed({in_m31[15], in_m31});
      if (h > 0) begin
        a_rad_nxt = 31'(h) << (FRAC_BITS - 1);
      end
    end else if (t > -ONE_S && t < THREE_S) begin
      a_side_nxt.code = CASE_GENERAL;
      a_rad_nxt       = prod[30:0];
    end else begin
      a_side_nxt.code = CASE_OOB;
    end
  end

  logic        a_vld_r;
  side_t       a_side_r;
  logic [30:0] a_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_rad_r  <= a_rad_nxt;
    end
  end

  // ---- square root, request data delayed alongside
  logic [15:0] root;
  logic        sq_vld_r  [SQRT_LAT];
  side_t       sq_side_r [SQRT_LAT];

  rmaa_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (a_rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) begin
        sq_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      sq_vld_r[0] <= a_vld_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        sq_vld_r[i] <= sq_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= a_side_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // ---- angle and axis quotients
  side_t              b_side;
  logic        [16:0] den;
  logic signed [15:0] q0;
  logic signed [15:0] q1;
  logic signed [15:0] q2;
  logic        [15:0] angle;

  always_comb begin
    b_side      = sq_side_r[SQRT_LAT-1];
    b_side.root = root;
  end

  // half turn divides by twice the root
  assign den = (b_side.code == CASE_HALF) ? {root, 1'b0} : {1'b0, root};

  rmaa_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .u     (b_side.u),
    .s     (root),
    .angle (angle)
  );

  rmaa_div u_div_x (
    .clk (clk),
    .en  (en),
    .num ($signed({b_side.n0, 14'b0})),
    .den (den),
    .quo (q0)
  );

  rmaa_div u_div_y (
    .clk (clk),
    .en  (en),
    .num ($signed({b_side.n1, 14'b0})),
    .den (den),
    .quo (q1)
  );

  rmaa_div u_div_z (
    .clk (clk),
    .en  (en),
    .num ($signed({b_side.n2, 14'b0})),
    .den (den),
    .quo (q2)
  );

  logic  bk_vld_r  [BACK_LAT];
  side_t bk_side_r [BACK_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_LAT; i++) begin
        bk_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      bk_vld_r[0] <= sq_vld_r[SQRT_LAT-1];
      for (int i = 1; i < BACK_LAT; i++) begin
        bk_vld_r[i] <= bk_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bk_side_r[0] <= b_side;
      for (int i = 1; i < BACK_LAT; i++) begin
        bk_side_r[i] <= bk_side_r[i-1];
      end
    end
  end

  // ---- output register
  side_t              f_side;
  logic        [15:0] angle_nxt;
  logic signed [15:0] ax_nxt;
  logic signed [15:0] ay_nxt;
  logic signed [15:0] az_nxt;

  assign f_side = bk_side_r[BACK_LAT-1];

  always_comb begin
    case (f_side.code)
      CASE_GENERAL: begin
        angle_nxt = angle;
        ax_nxt    = q0;
        ay_nxt    = q1;
        az_nxt    = q2;
      end
      CASE_ZERO: begin
        angle_nxt = '0;
        ax_nxt    = f_side.n0[15:0];
        ay_nxt    = f_side.n1[15:0];
        az_nxt    = f_side.n2[15:0];
      end
      CASE_HALF: begin
        angle_nxt = 16'(ANGLE_HALF);
        ax_nxt    = f_side.root[15] ? 16'sd32767 : $signed(f_side.root);
        ay_nxt    = q1;
        az_nxt    = q2;
      end
      default: begin
        angle_nxt = '0;
        ax_nxt    = '0;
        ay_nxt    = '0;
        az_nxt    = '0;
      end
    endcase
  end

  logic        [15:0] out_angle_deg_r;
  logic signed [15:0] out_axis_x_r;
  logic signed [15:0] out_axis_y_r;
  logic signed [15:0] out_axis_z_r;
  logic        [1:0]  out_case_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= bk_vld_r[BACK_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_deg_r <= angle_nxt;
      out_axis_x_r    <= ax_nxt;
      out_axis_y_r    <= ay_nxt;
      out_axis_z_r    <= az_nxt;
      out_case_code_r <= f_side.code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = out_angle_deg_r;
  assign out_axis_x    = out_axis_x_r;
  assign out_axis_y    = out_axis_y_r;
  assign out_axis_z    = out_axis_z_r;
  assign out_case_code = out_case_code_r;

endmodule
`default_nettype wire
